### rtl/ig_pkg.sv
package ig_pkg;

   localparam int FvW        = 8;
   localparam int LblW       = 8;
   localparam int NumValuesW = 5;
   localparam int GainW      = 18;
   localparam int TotalW     = 13;
   localparam int FracW      = 16;
   localparam int MantW      = 31;
   localparam int MantShift  = 30;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = 2;
   localparam int GainMax    = 131071;
   localparam int GainMin    = -131072;
   localparam logic [NumValuesW-1:0] NumValuesReset = 5'd2;

   typedef struct packed {
      logic [FvW-1:0] fv;
      logic           in_range;
      logic           is0;
      logic           is1;
      logic           last;
   } ig_row_type;

endpackage

### rtl/ig_if.sv
interface ig_req_if import ig_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [FvW-1:0]  feature_value;
   logic [LblW-1:0] class_label;
   logic            last_row;

   modport source (output valid, feature_value, class_label, last_row, input ready);
   modport sink (input valid, feature_value, class_label, last_row, output ready);
endinterface

interface ig_rsp_if import ig_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [GainW-1:0] gain;
   logic [TotalW-1:0]       row_total;

   modport source (output valid, gain, row_total, input ready);
   modport sink (input valid, gain, row_total, output ready);
endinterface

interface ig_csr_if import ig_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [NumValuesW-1:0] num_values;

   modport source (output valid, num_values, input ready);
   modport sink (input valid, num_values, output ready);
endinterface

### rtl/information_gain_binary_class.sv
// rows: one word per cycle into the queue while it is not full; a value outside the subsets
// is counted as it is popped, one inside goes through a count memory read, then a write back
// finish after the last row: the serial log2 unit does 3 logs per group (16 squarings per log)
// for the totals and for each value below the limit, then the bit-serial divider runs twice
// reset clears queue, totals and per-value valid bits at once; num_values resets to 2
// a finished result waits in the output register while the next set is counted
module information_gain_binary_class import ig_pkg::*; #(
   parameter int MAX_VALUES = 16,
   parameter int MAX_ROWS   = 4096
) (
   input logic     clock,
   input logic     reset,
   ig_req_if.sink  req,
   ig_rsp_if.source rsp,
   ig_csr_if.sink  csr
);

   localparam int LIMW = $clog2(MAX_VALUES + 1);

   logic [NumValuesW-1:0] num_values_ff, num_values_in;
   logic [LIMW-1:0]       limit;
   logic                  push, full, pop, empty;
   ig_row_type            push_row, pop_row;

   assign csr.ready = 1'b1;

   always_comb begin
      num_values_in = num_values_ff;
      if (csr.valid) begin
         num_values_in = csr.num_values;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_values_ff <= NumValuesReset;
      end else begin
         num_values_ff <= num_values_in;
      end
   end

   always_comb begin
      if (int'(num_values_ff) < MAX_VALUES) begin
         limit = LIMW'(num_values_ff);
      end else begin
         limit = LIMW'(MAX_VALUES);
      end
   end

   ig_front #(.LIMW(LIMW)) u_front (
      .req   (req),
      .limit (limit),
      .full  (full),
      .push  (push),
      .row   (push_row)
   );

   ig_fifo #(.WIDTH($bits(ig_row_type))) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_row),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_row),
      .empty     (empty)
   );

   ig_back #(
      .MAX_VALUES (MAX_VALUES),
      .MAX_ROWS   (MAX_ROWS),
      .LIMW       (LIMW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit),
      .row       (pop_row),
      .row_valid (!empty),
      .row_pop   (pop),
      .rsp       (rsp)
   );

endmodule

### rtl/ig_ram.sv
module ig_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ig_fifo.sv
module ig_fifo import ig_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0]     slot_ff [QueueDepth];
   logic [QueuePtrW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QueuePtrW:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (QueuePtrW+1)'(QueueDepth));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/ig_front.sv
module ig_front import ig_pkg::*; #(
   parameter int LIMW = 5
) (
   ig_req_if.sink           req,
   input  logic [LIMW-1:0]  limit,
   input  logic             full,
   output logic             push,
   output ig_row_type       row
);

   assign req.ready = !full;
   assign push      = req.valid && !full;

   always_comb begin
      row.fv       = req.feature_value;
      row.in_range = int'(req.feature_value) < int'(limit);
      row.is0      = (req.class_label == LblW'(0));
      row.is1      = (req.class_label == LblW'(1));
      row.last     = req.last_row;
   end

endmodule

### rtl/ig_log2.sv
module ig_log2 import ig_pkg::*; #(
   parameter int CW = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [CW-1:0]                 x,
   output logic                          done,
   output logic [$clog2(CW)+FracW-1:0]   value
);

   localparam int KW = $clog2(CW);
   localparam int LW = KW + FracW;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [MantW-1:0]   y_ff, y_in;
   logic [FracW-1:0]   frac_ff, frac_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [LW-1:0]      value_ff, value_in;
   logic [KW-1:0]      kx;
   logic [2*MantW-1:0] sq;
   logic [MantW:0]     y2;

   always_comb begin
      kx = '0;
      for (int i = 0; i < CW; i++) begin
         if (x[i]) begin
            kx = KW'(i);
         end
      end
   end

   assign sq = {{MantW{1'b0}}, y_ff} * {{MantW{1'b0}}, y_ff};
   assign y2 = sq[2*MantW-1:MantShift];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      y_in     = y_ff;
      frac_in  = frac_ff;
      k_in     = k_ff;
      value_in = value_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         k_in    = kx;
         frac_in = '0;
         y_in    = MantW'(x) << (MantShift - int'(kx));
      end else if (busy_ff) begin
         frac_in = {frac_ff[FracW-2:0], y2[MantW]};
         y_in    = y2[MantW] ? y2[MantW:1] : y2[MantW-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == 4'd15) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            value_in = {k_ff, frac_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      y_ff     <= y_in;
      frac_ff  <= frac_in;
      k_ff     <= k_in;
      value_ff <= value_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

### rtl/ig_div.sv
module ig_div #(
   parameter int DW = 40,
   parameter int CW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [CW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int NW = $clog2(DW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [CW:0]   trial;
   logic [CW:0]   diff;
   logic          ge;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[CW-1:0] : trial[CW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NW'(DW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/ig_back.sv
module ig_back import ig_pkg::*; #(
   parameter int MAX_VALUES = 16,
   parameter int MAX_ROWS   = 4096,
   parameter int LIMW       = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [LIMW-1:0] limit,
   input  ig_row_type      row,
   input  logic            row_valid,
   output logic            row_pop,
   ig_rsp_if.source        rsp
);

   localparam int CW = $clog2(MAX_ROWS + 1);
   localparam int VW = $clog2(MAX_VALUES);
   localparam int KW = $clog2(CW);
   localparam int LW = KW + FracW;
   localparam int TW = CW + LW;
   localparam int SW = TW + $clog2(2 * MAX_VALUES) + 1;
   localparam int RW = 3 * CW;
   localparam logic signed [SW:0] GMAX = (SW+1)'(GainMax);
   localparam logic signed [SW:0] GMIN = (SW+1)'(GainMin);

   typedef enum logic [3:0] {
      S_IDLE, S_UPD, S_GRP, S_RD, S_LOGN, S_LOGC0, S_LOGC1,
      S_MUL0, S_MUL1, S_ACC, S_DIVP, S_DIVW, S_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           tot_n_ff, tot_n_in, tot_c0_ff, tot_c0_in, tot_c1_ff, tot_c1_in;
   logic [MAX_VALUES-1:0]   valid_ff, valid_in;
   logic [VW-1:0]           cur_idx_ff, cur_idx_in;
   logic                    cur_is0_ff, cur_is0_in, cur_is1_ff, cur_is1_in;
   logic                    cur_last_ff, cur_last_in;
   logic [CW-1:0]           opn_ff, opn_in, opc0_ff, opc0_in, opc1_ff, opc1_in;
   logic [LW-1:0]           ln_ff, ln_in, lc0_ff, lc0_in, lc1_ff, lc1_in;
   logic [TW-1:0]           prod_ff, prod_in;
   logic [SW-1:0]           psum_ff, psum_in, wsum_ff, wsum_in;
   logic [SW-1:0]           parent_ff, parent_in, wq_ff, wq_in;
   logic                    is_total_ff, is_total_in;
   logic [LIMW-1:0]         v_ff, v_in;
   logic                    started_ff, started_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [GainW-1:0] gain_ff, gain_in;
   logic [TotalW-1:0]       total_ff, total_in;

   logic                    ram_wr_en, ram_rd_en;
   logic [VW-1:0]           ram_rd_addr;
   logic [RW-1:0]           ram_wr_data, ram_rd_data;
   logic [CW-1:0]           rd_n, rd_c0, rd_c1;
   logic                    lg_start, lg_done;
   logic [CW-1:0]           lg_x;
   logic [LW-1:0]           lg_value;
   logic                    dv_start, dv_done;
   logic [SW-1:0]           dv_dividend, dv_quotient;
   logic [LIMW-1:0]         v_next;
   logic [LW-1:0]           diff0, diff1;
   logic signed [SW:0]      gdiff;
   logic signed [GainW-1:0] gsat;

   function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
      return (c < CW'(MAX_ROWS)) ? c + CW'(1) : c;
   endfunction

   ig_ram #(.WIDTH(RW), .DEPTH(MAX_VALUES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cur_idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ig_log2 #(.CW(CW)) u_log2 (
      .clock (clock),
      .reset (reset),
      .start (lg_start),
      .x     (lg_x),
      .done  (lg_done),
      .value (lg_value)
   );

   ig_div #(.DW(SW), .CW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_dividend),
      .divisor  (tot_n_ff),
      .done     (dv_done),
      .quotient (dv_quotient)
   );

   assign rd_n   = ram_rd_data[CW-1:0];
   assign rd_c1  = ram_rd_data[2*CW-1:CW];
   assign rd_c0  = ram_rd_data[3*CW-1:2*CW];
   assign v_next = v_ff + LIMW'(1);
   assign diff0  = ln_ff - lc0_ff;
   assign diff1  = ln_ff - lc1_ff;
   assign gdiff  = $signed({1'b0, parent_ff}) - $signed({1'b0, wq_ff});

   always_comb begin
      if (gdiff > GMAX) begin
         gsat = GainW'(GainMax);
      end else if (gdiff < GMIN) begin
         gsat = GainW'(GainMin);
      end else begin
         gsat = gdiff[GainW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      tot_n_in     = tot_n_ff;
      tot_c0_in    = tot_c0_ff;
      tot_c1_in    = tot_c1_ff;
      valid_in     = valid_ff;
      cur_idx_in   = cur_idx_ff;
      cur_is0_in   = cur_is0_ff;
      cur_is1_in   = cur_is1_ff;
      cur_last_in  = cur_last_ff;
      opn_in       = opn_ff;
      opc0_in      = opc0_ff;
      opc1_in      = opc1_ff;
      ln_in        = ln_ff;
      lc0_in       = lc0_ff;
      lc1_in       = lc1_ff;
      prod_in      = prod_ff;
      psum_in      = psum_ff;
      wsum_in      = wsum_ff;
      parent_in    = parent_ff;
      wq_in        = wq_ff;
      is_total_in  = is_total_ff;
      v_in         = v_ff;
      started_in   = started_ff;
      out_valid_in = out_valid_ff;
      gain_in      = gain_ff;
      total_in     = total_ff;
      row_pop      = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = row.fv[VW-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_data  = '0;
      lg_start     = 1'b0;
      lg_x         = opn_ff;
      dv_start     = 1'b0;
      dv_dividend  = psum_ff;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (row_valid) begin
               row_pop     = 1'b1;
               tot_n_in    = bump(tot_n_ff);
               if (row.is0) begin
                  tot_c0_in = bump(tot_c0_ff);
               end
               if (row.is1) begin
                  tot_c1_in = bump(tot_c1_ff);
               end
               cur_idx_in  = row.fv[VW-1:0];
               cur_is0_in  = row.is0;
               cur_is1_in  = row.is1;
               cur_last_in = row.last;
               if (row.in_range) begin
                  ram_rd_en = 1'b1;
                  state_in  = S_UPD;
               end else if (row.last) begin
                  state_in = S_GRP;
               end
            end
         end
         S_UPD: begin
            ram_wr_en = 1'b1;
            if (valid_ff[cur_idx_ff]) begin
               ram_wr_data = {cur_is0_ff ? bump(rd_c0) : rd_c0,
                              cur_is1_ff ? bump(rd_c1) : rd_c1,
                              bump(rd_n)};
            end else begin
               ram_wr_data = {cur_is0_ff ? CW'(1) : CW'(0),
                              cur_is1_ff ? CW'(1) : CW'(0),
                              CW'(1)};
            end
            valid_in[cur_idx_ff] = 1'b1;
            state_in = cur_last_ff ? S_GRP : S_IDLE;
         end
         S_GRP: begin
            opn_in      = tot_n_ff;
            opc0_in     = tot_c0_ff;
            opc1_in     = tot_c1_ff;
            is_total_in = 1'b1;
            v_in        = '0;
            psum_in     = '0;
            wsum_in     = '0;
            started_in  = 1'b0;
            state_in    = S_LOGN;
         end
         S_RD: begin
            if (valid_ff[v_ff[VW-1:0]]) begin
               opn_in  = rd_n;
               opc0_in = rd_c0;
               opc1_in = rd_c1;
            end else begin
               opn_in  = '0;
               opc0_in = '0;
               opc1_in = '0;
            end
            state_in = S_LOGN;
         end
         S_LOGN: begin
            lg_x = opn_ff;
            if (!started_ff) begin
               lg_start   = 1'b1;
               started_in = 1'b1;
            end else if (lg_done) begin
               ln_in      = lg_value;
               started_in = 1'b0;
               state_in   = S_LOGC0;
            end
         end
         S_LOGC0: begin
            lg_x = opc0_ff;
            if (!started_ff) begin
               lg_start   = 1'b1;
               started_in = 1'b1;
            end else if (lg_done) begin
               lc0_in     = lg_value;
               started_in = 1'b0;
               state_in   = S_LOGC1;
            end
         end
         S_LOGC1: begin
            lg_x = opc1_ff;
            if (!started_ff) begin
               lg_start   = 1'b1;
               started_in = 1'b1;
            end else if (lg_done) begin
               lc1_in     = lg_value;
               started_in = 1'b0;
               state_in   = S_MUL0;
            end
         end
         S_MUL0: begin
            prod_in  = TW'(opc0_ff) * TW'(diff0);
            state_in = S_MUL1;
         end
         S_MUL1: begin
            if (is_total_ff) begin
               psum_in = psum_ff + SW'(prod_ff);
            end else begin
               wsum_in = wsum_ff + SW'(prod_ff);
            end
            prod_in  = TW'(opc1_ff) * TW'(diff1);
            state_in = S_ACC;
         end
         S_ACC: begin
            if (is_total_ff) begin
               psum_in     = psum_ff + SW'(prod_ff);
               is_total_in = 1'b0;
               if (limit == '0) begin
                  state_in = S_DIVP;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  state_in    = S_RD;
               end
            end else begin
               wsum_in = wsum_ff + SW'(prod_ff);
               if (v_next == limit) begin
                  state_in = S_DIVP;
               end else begin
                  v_in        = v_next;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = v_next[VW-1:0];
                  state_in    = S_RD;
               end
            end
         end
         S_DIVP: begin
            dv_dividend = psum_ff;
            if (!started_ff) begin
               dv_start   = 1'b1;
               started_in = 1'b1;
            end else if (dv_done) begin
               parent_in  = dv_quotient;
               started_in = 1'b0;
               state_in   = S_DIVW;
            end
         end
         S_DIVW: begin
            dv_dividend = wsum_ff;
            if (!started_ff) begin
               dv_start   = 1'b1;
               started_in = 1'b1;
            end else if (dv_done) begin
               wq_in      = dv_quotient;
               started_in = 1'b0;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               gain_in      = gsat;
               total_in     = TotalW'(tot_n_ff);
               tot_n_in     = '0;
               tot_c0_in    = '0;
               tot_c1_in    = '0;
               valid_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_idx_ff  <= cur_idx_in;
      cur_is0_ff  <= cur_is0_in;
      cur_is1_ff  <= cur_is1_in;
      cur_last_ff <= cur_last_in;
      opn_ff      <= opn_in;
      opc0_ff     <= opc0_in;
      opc1_ff     <= opc1_in;
      ln_ff       <= ln_in;
      lc0_ff      <= lc0_in;
      lc1_ff      <= lc1_in;
      prod_ff     <= prod_in;
      psum_ff     <= psum_in;
      wsum_ff     <= wsum_in;
      parent_ff   <= parent_in;
      wq_ff       <= wq_in;
      is_total_ff <= is_total_in;
      v_ff        <= v_in;
      gain_ff     <= gain_in;
      total_ff    <= total_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         tot_n_ff     <= '0;
         tot_c0_ff    <= '0;
         tot_c1_ff    <= '0;
         valid_ff     <= '0;
         started_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tot_n_ff     <= tot_n_in;
         tot_c0_ff    <= tot_c0_in;
         tot_c1_ff    <= tot_c1_in;
         valid_ff     <= valid_in;
         started_ff   <= started_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.gain      = gain_ff;
   assign rsp.row_total = total_ff;

   a_c0_bounded: assert property (@(posedge clock) disable iff (reset)
      tot_c0_ff <= tot_n_ff) else $error("class 0 total above row total");

   a_c1_bounded: assert property (@(posedge clock) disable iff (reset)
      tot_c1_ff <= tot_n_ff) else $error("class 1 total above row total");

   a_upd_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPD |-> $past(row_pop) && $past(state_ff) == S_IDLE)
      else $error("count update without a popped word");

   a_out_ready_only: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && out_valid_ff && !rsp.ready |=> state_ff == S_OUT)
      else $error("result overwritten while still pending");

endmodule
